FILE: rtl/lsb_stego_stream_extractor_assert.svh
// Assertion macros used by the stego extractor top level.
`ifndef LSB_STEGO_STREAM_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_STREAM_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsse assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsse assertion failed");

`endif

FILE: rtl/lsse_pkg.sv
// Package with types and constants of the stego stream extractor.
package lsse_pkg;

	localparam int unsigned LSSE_MAGIC_CHARS = 2;
	localparam logic [7:0]  LSSE_HEADER_SKIP_RST = 8'd54;
	localparam logic [15:0] LSSE_MAGIC_VALUE_RST = 16'h232A;
	localparam int unsigned LSSE_ADDR_W = 3;
	localparam int unsigned LSSE_DATA_W = 32;

	typedef enum logic [1:0] {
		KIND_EXT       = 2'd0,
		KIND_PAY       = 2'd1,
		KIND_BAD_MAGIC = 2'd2,
		KIND_EMPTY     = 2'd3
	} lsse_kind_t;

	typedef enum logic [0:0] {
		REG_HEADER_SKIP = 1'b0,
		REG_MAGIC_VALUE = 1'b1
	} lsse_reg_t;

	typedef struct packed {
		logic data_bit;
		logic restart;
	} lsse_item_t;

	typedef struct packed {
		logic [7:0]  header_skip;
		logic [15:0] magic_value;
	} lsse_cfg_t;

endpackage

FILE: rtl/lsse_if.sv
// Valid/ready channel interfaces for cover bytes and decoded results.
interface lsse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] cover_byte;
	logic       restart;

	modport source (output valid, cover_byte, restart, input ready);
	modport sink (input valid, cover_byte, restart, output ready);
endinterface

interface lsse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic       last;

	modport source (output valid, out_byte, out_kind, last, input ready);
	modport sink (input valid, out_byte, out_kind, last, output ready);
endinterface

FILE: rtl/lsse_cfg_regs.sv
// APB register file holding the header skip count and the magic value.
module lsse_cfg_regs
	import lsse_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [LSSE_ADDR_W-1:0] paddr,
	input  logic [LSSE_DATA_W-1:0] pwdata,
	output logic [LSSE_DATA_W-1:0] prdata,
	output logic                   pready,
	output lsse_cfg_t              cfg
);

	lsse_cfg_t cfg_q;
	lsse_reg_t reg_sel;
	logic      wr_en;

	assign reg_sel = lsse_reg_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_skip <= LSSE_HEADER_SKIP_RST;
			cfg_q.magic_value <= LSSE_MAGIC_VALUE_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_HEADER_SKIP: cfg_q.header_skip <= pwdata[7:0];
				REG_MAGIC_VALUE: cfg_q.magic_value <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_HEADER_SKIP: prdata = {24'd0, cfg_q.header_skip};
			REG_MAGIC_VALUE: prdata = {16'd0, cfg_q.magic_value};
			default: prdata = '0;
		endcase
	end

endmodule

FILE: rtl/lsse_in_stage.sv
// Input register that captures one cover beat for the parser.
module lsse_in_stage
	import lsse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lsse_in_if.sink    cover_in,
	input  logic       advance,
	output logic       item_valid,
	output lsse_item_t item
);

	logic       valid_s1;
	lsse_item_t item_s1;

	assign cover_in.ready = !valid_s1 || advance;
	assign item_valid     = valid_s1;
	assign item           = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cover_in.valid && cover_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cover_in.valid && cover_in.ready) begin
			item_s1.data_bit <= cover_in.cover_byte[0];
			item_s1.restart  <= cover_in.restart;
		end
	end

endmodule

FILE: rtl/lsse_parser.sv
// Frame parser: header skip, bit gathering, field decode and result register.
module lsse_parser
	import lsse_pkg::*;
#(
	parameter int unsigned MAGIC_CHARS = LSSE_MAGIC_CHARS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  lsse_item_t item,
	input  lsse_cfg_t  cfg,
	output logic       advance,
	lsse_out_if.source result_out
);

	localparam int unsigned MIDX_W = (MAGIC_CHARS > 1) ? $clog2(MAGIC_CHARS) : 1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_MAGIC,
		PH_EXT_LEN,
		PH_EXT,
		PH_PAY_LEN,
		PH_PAY,
		PH_DONE
	} phase_t;

	phase_t            phase_q, cur_phase, work_phase, nxt_phase;
	logic [7:0]        hdr_q, cur_hdr, nxt_hdr;
	logic [4:0]        bits_q, cur_bits, nxt_bits;
	logic [31:0]       acc_q, cur_acc, nxt_acc;
	logic [31:0]       rem_q, cur_rem, nxt_rem;
	logic [MIDX_W-1:0] midx_q, cur_midx, nxt_midx;
	logic              take_bit;
	logic              complete;
	logic [31:0]       word;
	logic [7:0]        exp_magic;
	logic              emit;
	logic [7:0]        res_byte;
	lsse_kind_t        res_kind;
	logic              res_last;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	lsse_kind_t        out_kind_q;
	logic              out_last_q;

	assign advance = item_valid && (!out_valid_q || result_out.ready);

	assign result_out.valid    = out_valid_q;
	assign result_out.out_byte = out_byte_q;
	assign result_out.out_kind = out_kind_q;
	assign result_out.last     = out_last_q;

	always_comb begin
		cur_phase = item.restart ? PH_HEADER : phase_q;
		cur_hdr   = item.restart ? 8'd0 : hdr_q;
		cur_bits  = item.restart ? 5'd0 : bits_q;
		cur_acc   = item.restart ? 32'd0 : acc_q;
		cur_rem   = item.restart ? 32'd0 : rem_q;
		cur_midx  = item.restart ? '0 : midx_q;

		nxt_phase = cur_phase;
		nxt_hdr   = cur_hdr;
		nxt_bits  = cur_bits;
		nxt_acc   = cur_acc;
		nxt_rem   = cur_rem;
		nxt_midx  = cur_midx;
		emit      = 1'b0;
		res_byte  = 8'd0;
		res_kind  = KIND_EXT;
		res_last  = 1'b0;
		take_bit  = 1'b0;

		if (cur_midx == MIDX_W'(MAGIC_CHARS - 1)) begin
			exp_magic = cfg.magic_value[7:0];
		end else if (MAGIC_CHARS >= 2 && cur_midx == MIDX_W'(MAGIC_CHARS - 2)) begin
			exp_magic = cfg.magic_value[15:8];
		end else begin
			exp_magic = 8'd0;
		end

		if (cur_phase == PH_HEADER) begin
			if (cur_hdr < cfg.header_skip) begin
				nxt_hdr = cur_hdr + 8'd1;
			end else begin
				take_bit = 1'b1;
			end
		end else if (cur_phase != PH_DONE) begin
			take_bit = 1'b1;
		end

		work_phase = (cur_phase == PH_HEADER) ? PH_MAGIC : cur_phase;
		word       = {cur_acc[30:0], item.data_bit};
		complete   = (work_phase == PH_EXT_LEN || work_phase == PH_PAY_LEN) ?
			(cur_bits == 5'd31) : (cur_bits == 5'd7);

		if (take_bit) begin
			nxt_phase = work_phase;
			if (!complete) begin
				nxt_acc  = word;
				nxt_bits = cur_bits + 5'd1;
			end else begin
				nxt_acc  = 32'd0;
				nxt_bits = 5'd0;
				case (work_phase)
					PH_MAGIC: begin
						if (word[7:0] != exp_magic) begin
							nxt_phase = PH_DONE;
							emit      = 1'b1;
							res_kind  = KIND_BAD_MAGIC;
							res_last  = 1'b1;
						end else if (cur_midx == MIDX_W'(MAGIC_CHARS - 1)) begin
							nxt_phase = PH_EXT_LEN;
						end else begin
							nxt_midx = cur_midx + MIDX_W'(1);
						end
					end
					PH_EXT_LEN: begin
						nxt_rem   = word;
						nxt_phase = (word == 32'd0) ? PH_PAY_LEN : PH_EXT;
					end
					PH_EXT: begin
						nxt_rem  = cur_rem - 32'd1;
						emit     = 1'b1;
						res_byte = word[7:0];
						res_kind = KIND_EXT;
						if (cur_rem == 32'd1) begin
							nxt_phase = PH_PAY_LEN;
						end
					end
					PH_PAY_LEN: begin
						nxt_rem = word;
						if (word == 32'd0) begin
							nxt_phase = PH_DONE;
							emit      = 1'b1;
							res_kind  = KIND_EMPTY;
							res_last  = 1'b1;
						end else begin
							nxt_phase = PH_PAY;
						end
					end
					PH_PAY: begin
						nxt_rem  = cur_rem - 32'd1;
						emit     = 1'b1;
						res_byte = word[7:0];
						res_kind = KIND_PAY;
						if (cur_rem == 32'd1) begin
							nxt_phase = PH_DONE;
							res_last  = 1'b1;
						end
					end
					default: nxt_phase = PH_DONE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_q       <= 8'd0;
			bits_q      <= 5'd0;
			acc_q       <= 32'd0;
			rem_q       <= 32'd0;
			midx_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= nxt_phase;
			hdr_q       <= nxt_hdr;
			bits_q      <= nxt_bits;
			acc_q       <= nxt_acc;
			rem_q       <= nxt_rem;
			midx_q      <= nxt_midx;
			out_valid_q <= emit;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_byte_q <= res_byte;
			out_kind_q <= res_kind;
			out_last_q <= res_last;
		end
	end

endmodule

FILE: rtl/lsb_stego_stream_extractor.sv
// Top level of the LSB stego stream extractor.
//
// Channel     Direction  Beat contents
// cover_in    sink       cover_byte[7:0], restart
// result_out  source     out_byte[7:0], out_kind[1:0], last
// apb         slave      header_skip at 0x0, magic_value at 0x4
//
// One cover beat per cycle is sustained while results are taken; a beat waits in the input
// register, and any result it yields is loaded into the result register as the parser advances.
// The parser state and the result register advance together, so a stalled
// result holds the parser and then the input register.
// Reset clears the parse state and loads header_skip 54 and magic_value 0x232A.
module lsb_stego_stream_extractor
	import lsse_pkg::*;
#(
	parameter int unsigned MAGIC_CHARS = LSSE_MAGIC_CHARS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	lsse_in_if.sink                cover_in,
	lsse_out_if.source             result_out,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [LSSE_ADDR_W-1:0] paddr,
	input  logic [LSSE_DATA_W-1:0] pwdata,
	output logic [LSSE_DATA_W-1:0] prdata,
	output logic                   pready
);

	`include "lsb_stego_stream_extractor_assert.svh"

	lsse_cfg_t  cfg;
	logic       advance;
	logic       item_valid;
	lsse_item_t item;

	lsse_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lsse_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.cover_in   (cover_in),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	lsse_parser #(
		.MAGIC_CHARS (MAGIC_CHARS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.cfg        (cfg),
		.advance    (advance),
		.result_out (result_out)
	);

	`LSSE_ASSERT_NOW(a_no_advance_when_stalled, clk, arst_n, result_out.valid && !result_out.ready, !advance)
	`LSSE_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !item_valid, cover_in.ready)
	`LSSE_ASSERT_NOW(a_status_is_last, clk, arst_n, result_out.valid && (result_out.out_kind == KIND_BAD_MAGIC || result_out.out_kind == KIND_EMPTY), result_out.last && result_out.out_byte == 8'd0)
	`LSSE_ASSERT_NEXT(a_accept_fills_stage, clk, arst_n, cover_in.valid && cover_in.ready, item_valid)

endmodule

FILE: tb/lsb_stego_stream_extractor_test.sv
`timescale 1ns / 100ps
// Testbench for the LSB stego stream extractor: directed and random cover images against a predictor.
module lsb_stego_stream_extractor_test;
	import lsse_pkg::*;

	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_BEATS = 200;
	localparam int PRINT_CAP = 40;

	typedef enum logic [2:0] {
		STEP_HEADER,
		STEP_MAGIC,
		STEP_EXT_LEN,
		STEP_EXT,
		STEP_PAY_LEN,
		STEP_PAY,
		STEP_DONE
	} scan_step_t;

	typedef struct packed {
		logic [7:0] data;
		lsse_kind_t kind;
		logic       last;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [LSSE_ADDR_W-1:0] paddr;
	logic [LSSE_DATA_W-1:0] pwdata;
	logic [LSSE_DATA_W-1:0] prdata;
	logic pready;

	lsse_in_if cover_bus();
	lsse_out_if result_bus();

	lsb_stego_stream_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cover_in(cover_bus),
		.result_out(result_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Predictor state and its copy of the registers.
	logic [7:0] cfg_header_skip;
	logic [15:0] cfg_magic;
	scan_step_t scan_step;
	logic [7:0] skipped_bytes;
	int bit_fill;
	logic [31:0] shift_word;
	logic [31:0] left_in_field;
	int magic_pos;

	decoded_t pending_decodes[$];
	bit frame_bits[$];

	int mismatch_count = 0;
	int cover_beats = 0;
	int parsed_beats = 0;
	int result_beats = 0;
	int images_sent = 0;
	int reg_writes = 0;

	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic logic [7:0] magic_byte(input logic [15:0] mg, input int pos);
		int sh;
		sh = 8 * (int'(LSSE_MAGIC_CHARS) - 1 - pos);
		if (sh >= 16)
			return 8'h00;
		return 8'(mg >> sh);
	endfunction

	function automatic void clear_scan();
		scan_step = STEP_HEADER;
		skipped_bytes = '0;
		bit_fill = 0;
		shift_word = '0;
		left_in_field = '0;
		magic_pos = 0;
	endfunction

	function automatic void expect_result(input logic [7:0] d, input lsse_kind_t k, input logic l);
		decoded_t r;
		r.data = d;
		r.kind = k;
		r.last = l;
		pending_decodes.push_back(r);
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	task automatic decode_cover_beat(input logic [7:0] b, input logic rs);
		logic [31:0] word;
		int need;
		if (rs)
			clear_scan();
		if (scan_step == STEP_HEADER) begin
			if (skipped_bytes < cfg_header_skip) begin
				skipped_bytes++;
				return;
			end
			scan_step = STEP_MAGIC;
		end
		if (scan_step == STEP_DONE)
			return;
		parsed_beats++;
		shift_word = {shift_word[30:0], b[0]};
		bit_fill++;
		need = (scan_step == STEP_EXT_LEN || scan_step == STEP_PAY_LEN) ? 32 : 8;
		if (bit_fill < need)
			return;
		word = shift_word;
		bit_fill = 0;
		shift_word = '0;
		case (scan_step)
			STEP_MAGIC: begin
				if (word[7:0] != magic_byte(cfg_magic, magic_pos)) begin
					scan_step = STEP_DONE;
					expect_result(8'h00, KIND_BAD_MAGIC, 1'b1);
				end else begin
					magic_pos++;
					if (magic_pos >= int'(LSSE_MAGIC_CHARS))
						scan_step = STEP_EXT_LEN;
				end
			end
			STEP_EXT_LEN: begin
				left_in_field = word;
				scan_step = (word == 32'd0) ? STEP_PAY_LEN : STEP_EXT;
			end
			STEP_EXT: begin
				left_in_field--;
				if (left_in_field == 32'd0)
					scan_step = STEP_PAY_LEN;
				expect_result(word[7:0], KIND_EXT, 1'b0);
			end
			STEP_PAY_LEN: begin
				left_in_field = word;
				if (word == 32'd0) begin
					scan_step = STEP_DONE;
					expect_result(8'h00, KIND_EMPTY, 1'b1);
				end else begin
					scan_step = STEP_PAY;
				end
			end
			default: begin
				left_in_field--;
				if (left_in_field == 32'd0) begin
					scan_step = STEP_DONE;
					expect_result(word[7:0], KIND_PAY, 1'b1);
				end else begin
					expect_result(word[7:0], KIND_PAY, 1'b0);
				end
			end
		endcase
	endtask

	task automatic send_cover(input logic [7:0] b, input logic rs);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			cover_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cover_bus.valid <= 1'b1;
		cover_bus.cover_byte <= b;
		cover_bus.restart <= rs;
		do
			@(posedge clk);
		while (!cover_bus.ready);
		cover_beats++;
		decode_cover_beat(b, rs);
	endtask

	task automatic wait_results_done();
		cover_bus.valid <= 1'b0;
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input lsse_reg_t r, input logic [31:0] v);
		wait_results_done();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_HEADER_SKIP: cfg_header_skip = v[7:0];
			default: cfg_magic = v[15:0];
		endcase
		reg_writes++;
	endtask

	task automatic read_reg(input lsse_reg_t r, input logic [31:0] want);
		cover_bus.valid <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {r, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== want)
			report_mismatch($sformatf("%s read %08h want %08h", r.name(), prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic void push_field(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			frame_bits.push_back(v[i]);
	endfunction

	function automatic void build_frame(input logic [15:0] mg, input logic [31:0] ext_len,
			input int ext_n, input logic [31:0] pay_len, input int pay_n);
		frame_bits.delete();
		for (int k = 0; k < int'(LSSE_MAGIC_CHARS); k++)
			push_field(magic_byte(mg, k), 8);
		push_field(ext_len, 32);
		repeat (ext_n) push_field($urandom, 8);
		push_field(pay_len, 32);
		repeat (pay_n) push_field($urandom, 8);
	endfunction

	task automatic send_header(input int n);
		for (int i = 0; i < n; i++)
			send_cover(8'($urandom), i == 0);
	endtask

	task automatic send_bits(input int lo, input int hi, input bit restart_first);
		for (int i = lo; i < hi; i++)
			send_cover({7'($urandom), frame_bits[i]}, restart_first && i == lo);
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_cover(8'($urandom), 1'b0);
	endtask

	task automatic send_image(input int skip_n, input int tail_n);
		send_header(skip_n);
		send_bits(0, frame_bits.size(), skip_n == 0);
		send_noise(tail_n);
		images_sent++;
	endtask

	always @(posedge clk) begin : check_results
		decoded_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			result_beats++;
			if (pending_decodes.size() == 0) begin
				report_mismatch($sformatf("result beat %02h kind %0d with nothing expected",
					result_bus.out_byte, result_bus.out_kind));
			end else begin
				want = pending_decodes.pop_front();
				if (result_bus.out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h want %02h",
						result_bus.out_byte, want.data));
				if (result_bus.out_kind !== want.kind)
					report_mismatch($sformatf("out_kind %0d want %s",
						result_bus.out_kind, want.kind.name()));
				if (result_bus.last !== want.last)
					report_mismatch($sformatf("last %b want %b", result_bus.last, want.last));
			end
		end
	end

	always @(posedge clk) begin : drive_result_ready
		if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_bus.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_bus.ready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
			stall_left = pick_gap();
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	task automatic test_reset_config_frame();
		build_frame(cfg_magic, 32'd2, 2, 32'd3, 3);
		send_image(cfg_header_skip, 4);
	endtask

	task automatic test_register_access();
		read_reg(REG_HEADER_SKIP, {24'h0, LSSE_HEADER_SKIP_RST});
		read_reg(REG_MAGIC_VALUE, {16'h0, LSSE_MAGIC_VALUE_RST});
		write_reg(REG_HEADER_SKIP, 32'd255);
		read_reg(REG_HEADER_SKIP, 32'd255);
		write_reg(REG_MAGIC_VALUE, 32'h0000_FFFF);
		read_reg(REG_MAGIC_VALUE, 32'h0000_FFFF);
		write_reg(REG_HEADER_SKIP, 32'd0);
		read_reg(REG_HEADER_SKIP, 32'd0);
		write_reg(REG_MAGIC_VALUE, 32'd0);
		read_reg(REG_MAGIC_VALUE, 32'd0);
	endtask

	task automatic test_empty_payload();
		build_frame(cfg_magic, 32'd0, 0, 32'd0, 0);
		send_image(cfg_header_skip, 6);
		write_reg(REG_MAGIC_VALUE, 32'h0000_FFFF);
		build_frame(cfg_magic, 32'd2, 2, 32'd0, 0);
		send_image(cfg_header_skip, 2);
		build_frame(cfg_magic, 32'd0, 0, 32'd1, 1);
		send_image(cfg_header_skip, 3);
	endtask

	task automatic test_magic_mismatch();
		write_reg(REG_HEADER_SKIP, 32'd1);
		write_reg(REG_MAGIC_VALUE, 32'h0000_5AA5);
		build_frame(cfg_magic ^ 16'h8000, 32'd0, 0, 32'd0, 0);
		send_header(cfg_header_skip);
		send_bits(0, 24, cfg_header_skip == 0);
		build_frame(cfg_magic ^ 16'h0001, 32'd0, 0, 32'd0, 0);
		send_header(cfg_header_skip);
		send_bits(0, 24, cfg_header_skip == 0);
		images_sent += 2;
	endtask

	task automatic test_restart_mid_frame();
		write_reg(REG_HEADER_SKIP, 32'd3);
		build_frame(cfg_magic, 32'd2, 2, 32'd6, 6);
		send_header(3);
		send_bits(0, frame_bits.size() - 20, 1'b0);
		send_header(2);
		build_frame(cfg_magic, 32'd2, 2, 32'd3, 3);
		send_image(cfg_header_skip, 2);
	endtask

	task automatic test_long_lengths();
		build_frame(cfg_magic, 32'hFFFF_FFFF, 3, 32'd1, 0);
		send_header(cfg_header_skip);
		send_bits(0, int'(LSSE_MAGIC_CHARS) * 8 + 32 + 24, cfg_header_skip == 0);
		build_frame(cfg_magic, 32'd0, 0, 32'h8000_0001, 3);
		send_image(cfg_header_skip, 8);
		images_sent++;
	endtask

	task automatic test_max_skip();
		write_reg(REG_HEADER_SKIP, 32'd255);
		write_reg(REG_MAGIC_VALUE, {16'h0, 16'($urandom)});
		build_frame(cfg_magic, 32'd1, 1, 32'd2, 2);
		send_image(cfg_header_skip, 3);
	endtask

	task automatic test_config_midstream();
		write_reg(REG_HEADER_SKIP, 32'd8);
		write_reg(REG_MAGIC_VALUE, 32'h0000_3C7E);
		send_header(5);
		// The skip drops below the bytes already seen, so the next beat is data.
		write_reg(REG_HEADER_SKIP, 32'd3);
		build_frame(16'h3C19, 32'd1, 1, 32'd2, 2);
		send_bits(0, 8, 1'b0);
		// The second magic character is checked against the new value.
		write_reg(REG_MAGIC_VALUE, 32'h0000_A519);
		send_bits(8, frame_bits.size(), 1'b0);
		send_noise(2);
		images_sent++;
	endtask

	task automatic test_backpressure();
		int half;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_reg(REG_HEADER_SKIP, 32'd2);
		build_frame(cfg_magic, 32'd1, 1, 32'd8, 8);
		hold_ask++;
		send_image(cfg_header_skip, 3);
		build_frame(cfg_magic, 32'd1, 1, 32'd2, 2);
		half = frame_bits.size() / 2;
		send_header(cfg_header_skip);
		send_bits(0, half, 1'b0);
		wait_results_done();
		send_bits(half, frame_bits.size(), 1'b0);
		images_sent++;
	endtask

	task automatic test_random_images();
		int goal;
		int style;
		int r;
		int skip_n;
		int ext_n;
		int pay_n;
		int cut;
		logic [15:0] mg;
		goal = cover_beats + RANDOM_BEATS;
		while (cover_beats < goal) begin
			if ($urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					write_reg(REG_HEADER_SKIP, $urandom_range(0, 4));
				else if (r < 90)
					write_reg(REG_HEADER_SKIP, $urandom_range(5, 60));
				else if (r < 96)
					write_reg(REG_HEADER_SKIP, 32'd54);
				else
					write_reg(REG_HEADER_SKIP, 32'd255);
				if ($urandom_range(0, 1) == 0)
					write_reg(REG_MAGIC_VALUE, {16'h0, 16'($urandom)});
			end
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			style = $urandom_range(0, 99);
			if (style >= 94) begin
				send_cover(8'($urandom), 1'b1);
				repeat ($urandom_range(10, 60))
					send_cover(8'($urandom), $urandom_range(0, 15) == 0);
				images_sent++;
			end else begin
				ext_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
				pay_n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
				mg = cfg_magic;
				skip_n = cfg_header_skip;
				if (style < 8)
					mg = mg ^ (16'h1 << $urandom_range(0, 15));
				else if (style < 12)
					skip_n = (skip_n > 0 && $urandom_range(0, 1) == 0) ? skip_n - 1 : skip_n + 1;
				build_frame(mg, ext_n, ext_n, pay_n, pay_n);
				cut = frame_bits.size();
				if (style >= 12 && style < 22)
					cut = $urandom_range(1, cut - 1);
				send_header(skip_n);
				send_bits(0, cut, skip_n == 0);
				send_noise($urandom_range(0, 5));
				images_sent++;
			end
		end
	endtask

	initial begin : run_regression
		arst_n = 1'b0;
		cover_bus.valid = 1'b0;
		cover_bus.cover_byte = 8'h00;
		cover_bus.restart = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_header_skip = LSSE_HEADER_SKIP_RST;
		cfg_magic = LSSE_MAGIC_VALUE_RST;
		clear_scan();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		test_reset_config_frame();
		test_register_access();
		test_empty_payload();
		test_magic_mismatch();
		test_restart_mid_frame();
		test_long_lengths();
		test_max_skip();
		test_config_midstream();
		test_backpressure();
		test_random_images();

		wait_results_done();
		$display("Sent %0d cover beats in %0d images (%0d carried hidden bits), %0d register writes.",
			cover_beats, images_sent, parsed_beats, reg_writes);
		$display("Checked %0d result beats, %0d mismatches.", result_beats, mismatch_count);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("Timed out with %0d results still expected.", pending_decodes.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lsse_pkg.sv
rtl/lsse_if.sv
rtl/lsse_cfg_regs.sv
rtl/lsse_in_stage.sv
rtl/lsse_parser.sv
rtl/lsb_stego_stream_extractor.sv
tb/lsb_stego_stream_extractor_test.sv
